// ----- hw/rtl/ccb_pkg.sv -----
`timescale 1ns / 1ps
package ccb_pkg;

  localparam int unsigned ChanW = 16;
  localparam int unsigned PixW  = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    REG_KTOP  = 3'd0,
    REG_KMID  = 3'd1,
    REG_KBOT  = 3'd2,
    REG_STR   = 3'd3,
    REG_FALPH = 3'd4,
    REG_WIDTH = 3'd5,
    REG_HGHT  = 3'd6
  } reg_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;     // latch the accepted item and clear the tap counters
    logic rd;        // line store read has been issued, take data
    logic mac_step;  // one tap of the channel sums
    logic blend;     // form blended results
    logic done;      // result taken or item dropped
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic drop;      // accepted item makes no result
    logic emit;      // item makes a result
    logic mac_last;  // last tap in progress
  } sts_t;

endpackage

// ----- hw/rtl/ccb_ctrl.sv -----
`timescale 1ns / 1ps
module ccb_ctrl
  import ccb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = sts_i.emit ? ST_MAC : ST_IDLE;
      ST_MAC:   if (sts_i.mac_last) state_d = ST_BLEND;
      ST_BLEND: state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_READ: begin
        cmd_o.rd   = 1'b1;
        cmd_o.done = sts_i.drop;
      end
      ST_MAC:   cmd_o.mac_step = 1'b1;
      ST_BLEND: cmd_o.blend = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.done  = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/ccb_dpath.sv -----
`timescale 1ns / 1ps
module ccb_dpath
  import ccb_pkg::*;
#(
  parameter int unsigned MaxWidth = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          op_i,
  input  logic [PixW-1:0] pix_i,
  output logic [PixW-1:0] res_o,
  output logic          eof_o
);

  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned CW = 14;

  logic [47:0] krow_q [3];
  logic [8:0]  str_q;
  logic        falpha_q;
  logic [12:0] wcfg_q, hcfg_q;

  logic [CW-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] lower_mem [MaxWidth];
  logic [PixW-1:0] up_rd_q, lo_rd_q;

  logic          op_q;
  logic [PixW-1:0] pix_q;
  logic          lrow_q;   // flush in the last row, window comes from the line stores
  logic          emit_q;
  logic [AW-1:0] rd_addr;
  logic [3:0]    tap_q;
  logic signed [37:0] acc_q [4];
  logic [PixW-1:0] mac_win [9];
  logic [PixW-1:0] res_q;
  logic          eof_q;
  logic          emit_d_w;
  logic          eof_d;
  logic [PixW-1:0] fwin_q [9];
  logic          fill_q;
  logic [PixW-1:0] fill_up_q, fill_lo_q;

  // effective sizes
  logic [CW-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = CW'(wcfg_q);
    if (wcfg_q == '0) w_eff = CW'(1);
    if (CW'(wcfg_q) > CW'(MaxWidth)) w_eff = CW'(MaxWidth);
    h_eff = CW'(hcfg_q);
    if (hcfg_q == '0) h_eff = CW'(1);
    if (CW'(hcfg_q) > CW'(4096)) h_eff = CW'(4096);
  end

  // classify the item and pick the read address
  logic          pix_ok, pix_emit, fl_ok, fl_last;
  logic [CW-1:0] oc_cl;
  always_comb begin
    pix_ok   = (in_row_q < h_eff) && (in_col_q < w_eff);
    pix_emit = (in_row_q >= CW'(1)) && ((in_col_q != '0) || (in_row_q >= CW'(2)));
    fl_ok    = in_row_q >= h_eff;
    fl_last  = out_row_q == h_eff - CW'(1);
    oc_cl    = (out_col_q < w_eff) ? out_col_q : w_eff - CW'(1);
    rd_addr  = in_col_q[AW-1:0];
  end

  // flush of last row builds its window from three reads
  logic [1:0]    frd_q;
  logic [CW-1:0] fcol;
  always_comb begin
    fcol = oc_cl;
    if (frd_q == 2'd0) fcol = (oc_cl == '0) ? '0 : oc_cl - CW'(1);
    if (frd_q == 2'd2) fcol = (oc_cl + CW'(1) < w_eff) ? oc_cl + CW'(1) : w_eff - CW'(1);
  end

  logic [AW-1:0] mem_addr;
  assign mem_addr = (cmd_i.mac_step && lrow_q) ? fcol[AW-1:0] : rd_addr;

  always_ff @(posedge clk_i) begin
    up_rd_q <= upper_mem[mem_addr];
    lo_rd_q <= lower_mem[mem_addr];
    if (cmd_i.rd && !op_q && pix_ok) begin
      upper_mem[rd_addr] <= (in_row_q == '0) ? pix_q : lo_rd_q;
      lower_mem[rd_addr] <= pix_q;
    end
  end

  assign emit_d_w = op_q ? fl_ok : (pix_ok && pix_emit);
  assign sts_o.drop = cmd_i.rd && !emit_d_w;
  assign sts_o.emit = emit_d_w;

  // flush of last row reads its three window columns from the line stores before taps start
  localparam logic [3:0] LastTap = 4'd8;
  assign sts_o.mac_last = (tap_q == LastTap);

  logic [PixW-1:0] col0, col1, col2;
  assign col0 = up_rd_q;
  assign col1 = lo_rd_q;
  assign col2 = pix_q;

  function automatic logic signed [16:0] wgt(input logic [47:0] r, input logic [1:0] c);
    logic [15:0] v;
    v = r[c*16 +: 16];
    return {v[15], v};
  endfunction

  logic [3:0] tap_r, tap_c;
  logic [1:0] tr, tc;
  always_comb begin
    if (tap_q >= 4'd6) tap_r = 4'd2;
    else if (tap_q >= 4'd3) tap_r = 4'd1;
    else tap_r = 4'd0;
  end
  assign tap_c = tap_q - tap_r * 4'd3;
  assign tr = tap_r[1:0];
  assign tc = tap_c[1:0];

  logic [PixW-1:0] tap_pix;
  assign tap_pix = mac_win[tap_q];

  assign eof_d = (out_col_q == w_eff - CW'(1)) && (out_row_q == h_eff - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      krow_q[0] <= '0;
      krow_q[1] <= 48'd16384;
      krow_q[2] <= '0;
      str_q     <= 9'd256;
      falpha_q  <= 1'b0;
      wcfg_q    <= 13'd1920;
      hcfg_q    <= 13'd1080;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      tap_q     <= '0;
      frd_q     <= '0;
      emit_q    <= 1'b0;
      fill_q    <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_KTOP:  krow_q[0] <= cfg_data_i[47:0];
          REG_KMID:  krow_q[1] <= cfg_data_i[47:0];
          REG_KBOT:  krow_q[2] <= cfg_data_i[47:0];
          REG_STR:   str_q <= cfg_data_i[8:0];
          REG_FALPH: falpha_q <= cfg_data_i[0];
          REG_WIDTH, REG_HGHT: begin
            if (reg_e'(cfg_idx_i) == REG_WIDTH) wcfg_q <= cfg_data_i[12:0];
            else hcfg_q <= cfg_data_i[12:0];
            in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        tap_q <= '0;
        frd_q <= '0;
      end
      if (cmd_i.rd) begin
        emit_q <= emit_d_w;
        if (!op_q && pix_ok) begin
          if (in_col_q + CW'(1) >= w_eff) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + CW'(1);
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
          if (in_row_q >= CW'(1)) begin
            for (int r = 0; r < 3; r++) begin
              if (in_col_q != '0) begin
                win_q[r*3]   <= win_q[r*3+1];
                win_q[r*3+1] <= win_q[r*3+2];
                win_q[r*3+2] <= (r == 0) ? col0 : (r == 1) ? col1 : col2;
              end else if (in_row_q >= CW'(2)) begin
                // right edge of the row above goes first, new column loads after blend
                win_q[r*3]   <= win_q[r*3+1];
                win_q[r*3+1] <= win_q[r*3+2];
              end else begin
                win_q[r*3]   <= (r == 0) ? col0 : (r == 1) ? col1 : col2;
                win_q[r*3+1] <= (r == 0) ? col0 : (r == 1) ? col1 : col2;
                win_q[r*3+2] <= (r == 0) ? col0 : (r == 1) ? col1 : col2;
              end
            end
            if (in_col_q == '0 && in_row_q >= CW'(2)) fill_q <= 1'b1;
          end
        end
        if (op_q && fl_ok && !fl_last) begin
          for (int r = 0; r < 3; r++) begin
            win_q[r*3]   <= win_q[r*3+1];
            win_q[r*3+1] <= win_q[r*3+2];
          end
        end
      end
      if (cmd_i.mac_step) begin
        if (lrow_q && frd_q != 2'd3) begin
          frd_q <= frd_q + 2'd1;
        end else begin
          tap_q <= tap_q + 4'd1;
        end
      end
      if (cmd_i.blend) begin
        if (fill_q) begin
          for (int i = 0; i < 3; i++) begin
            win_q[i]   <= fill_up_q;
            win_q[i+3] <= fill_lo_q;
            win_q[i+6] <= pix_q;
          end
          fill_q <= 1'b0;
        end
        if (eof_d) begin
          in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
        end else if (out_col_q + CW'(1) >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + CW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // payload registers
  logic [3:0] fidx;
  assign fidx = {2'd0, frd_q} - 4'd1;

  always_comb begin
    for (int i = 0; i < 9; i++) mac_win[i] = lrow_q ? fwin_q[i] : win_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_i;
      pix_q <= pix_i;
    end
    if (cmd_i.rd) begin
      lrow_q    <= op_q && fl_last;
      fill_up_q <= up_rd_q;
      fill_lo_q <= lo_rd_q;
    end
    // read data is registered and arrives in the cycle after the address
    if (cmd_i.mac_step && lrow_q && frd_q != 2'd0 && (frd_q != 2'd3 || tap_q == '0)) begin
      fwin_q[fidx]        <= up_rd_q;
      fwin_q[fidx + 4'd3] <= lo_rd_q;
      fwin_q[fidx + 4'd6] <= lo_rd_q;
    end
    if (cmd_i.mac_step && (!lrow_q || frd_q == 2'd3)) begin
      for (int k = 0; k < 4; k++) begin
        if (tap_q == '0) acc_q[k] <= 38'(wgt(krow_q[tr], tc) * $signed({1'b0, tap_pix[k*16 +: 16]}));
        else acc_q[k] <= acc_q[k] +
            38'(wgt(krow_q[tr], tc) * $signed({1'b0, tap_pix[k*16 +: 16]}));
      end
    end
    if (cmd_i.blend) begin
      eof_q <= eof_d;
      for (int k = 0; k < 4; k++) begin
        logic signed [47:0] o, t;
        logic [47:0] rr;
        o  = 48'($signed({1'b0, mac_win[4][k*16 +: 16]}));
        t  = (o <<< 22) + $signed({39'd0, str_q}) * (48'(acc_q[k]) - (o <<< 14));
        rr = 48'(t) + 48'd2097152;
        if (k == 3 && !falpha_q) res_q[k*16 +: 16] <= mac_win[4][k*16 +: 16];
        else if (t < 0) res_q[k*16 +: 16] <= '0;
        else if (rr[47:22] > 26'd65535) res_q[k*16 +: 16] <= 16'hFFFF;
        else res_q[k*16 +: 16] <= rr[37:22];
      end
    end
  end

  assign res_o = res_q;
  assign eof_o = eof_q;

  logic unused;
  assign unused = cmd_i.done ^ emit_q;

endmodule

// ----- hw/rtl/conv3x3_clamp_edge_blend.sv -----
`timescale 1ns / 1ps
// An item passes the read, MAC and blend states before its result is shown; a last-row
// flush first reads its window from the line stores. A new item is taken only when idle,
// after the last result is taken; the nine taps share one MAC. Dropped items end at read.
// Reset (rst_ni low, asynchronous) restores register defaults and clears all counters;
// line stores are not cleared.
module conv3x3_clamp_edge_blend
  import ccb_pkg::*;
#(
  parameter int unsigned MaxWidth = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic        m_axis_tlast,   // end_of_frame
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ccb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccb_dpath #(.MaxWidth(MaxWidth)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .cfg_we_i  (cfg_valid_i),
    .cfg_idx_i (cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .op_i      (s_axis_tuser),
    .pix_i     (s_axis_tdata),
    .res_o     (m_axis_tdata),
    .eof_o     (m_axis_tlast)
  );

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.rd, cmd.mac_step, cmd.blend})) else $error("commands overlap");
  a_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.blend |=> m_axis_tvalid) else $error("result not shown");

endmodule

// ----- verif/ccb_tb_pkg.sv -----
`timescale 1ns / 1ps
package ccb_tb_pkg;

  // Item kinds carried on s_axis_tuser.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage

// ----- verif/conv3x3_clamp_edge_blend_checker.sv -----
`timescale 1ns / 1ps
module conv3x3_clamp_edge_blend_checker
  import ccb_pkg::*;
  import ccb_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic        eof;
    logic [63:0] px;
  } px_out_t;

  logic [47:0] k_top, k_mid, k_bot;
  logic [8:0]  blend_w;
  logic        alpha_on;
  logic [12:0] width_q, height_q;

  logic [63:0] row_up [4096];
  logic [63:0] row_lo [4096];
  logic [63:0] win [9];
  int          in_col, in_row, out_col, out_row;

  px_out_t     expected_px [$];

  function automatic int eff_w();
    if (width_q < 1) return 1;
    if (width_q > 4096) return 4096;
    return int'(width_q);
  endfunction

  function automatic int eff_h();
    if (height_q < 1) return 1;
    if (height_q > 4096) return 4096;
    return int'(height_q);
  endfunction

  function automatic longint tap(int r, int c);
    logic [47:0] row;
    row = (r == 0) ? k_top : ((r == 1) ? k_mid : k_bot);
    return longint'($signed(row[16*c +: 16]));
  endfunction

  function automatic longint chan(logic [63:0] p, int k);
    return longint'({48'd0, p[16*k +: 16]});
  endfunction

  function automatic void shift_col(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2);
    for (int r = 0; r < 3; r++) begin
      win[r*3]     = win[r*3+1];
      win[r*3+1]   = win[r*3+2];
    end
    win[2] = c0;
    win[5] = c1;
    win[8] = c2;
  endfunction

  // Filter, blend and saturate one window, then advance the output position.
  function automatic void blend_window(logic [63:0] w [9]);
    px_out_t res;
    longint  orig, sum, t, v;
    int      wd, ht;
    wd = eff_w();
    ht = eff_h();
    for (int k = 0; k < 4; k++) begin
      orig = chan(w[4], k);
      if (k == 3 && !alpha_on) begin
        res.px[16*k +: 16] = orig[15:0];
      end else begin
        sum = 0;
        for (int i = 0; i < 9; i++) sum += tap(i / 3, i % 3) * chan(w[i], k);
        t = orig * 64'sd4194304 + longint'(blend_w) * (sum - orig * 64'sd16384);
        if (t < 0) begin
          v = 0;
        end else begin
          v = (t + 64'sd2097152) >>> 22;
          if (v > 65535) v = 65535;
        end
        res.px[16*k +: 16] = v[15:0];
      end
    end
    res.eof = (out_col == wd - 1) && (out_row == ht - 1);
    expected_px.push_back(res);
    out_col++;
    if (out_col >= wd) begin
      out_col = 0;
      out_row++;
    end
    if (res.eof) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
  endfunction

  function automatic void edge_emit();
    shift_col(win[2], win[5], win[8]);
    blend_window(win);
  endfunction

  function automatic void take_item(logic op, logic [63:0] data);
    int          wd, ht, oc;
    int          cs [3];
    logic [63:0] w [9];
    wd = eff_w();
    ht = eff_h();
    if (op == OP_PIXEL) begin
      if (in_row >= ht || in_col >= wd) return;
      if (in_row >= 1) begin
        if (in_col == 0) begin
          if (in_row >= 2) edge_emit();
          repeat (3) shift_col(row_up[0], row_lo[0], data);
        end else begin
          shift_col(row_up[in_col], row_lo[in_col], data);
          blend_window(win);
        end
      end
      if (in_row == 0) begin
        row_up[in_col] = data;
        row_lo[in_col] = data;
      end else begin
        row_up[in_col] = row_lo[in_col];
        row_lo[in_col] = data;
      end
      in_col++;
      if (in_col >= wd) begin
        in_col = 0;
        in_row++;
      end
    end else begin
      if (in_row < ht) return;
      if (out_row != ht - 1) begin
        edge_emit();
      end else begin
        // last row: bottom neighbours clamp to the lower line store
        oc = (out_col < wd) ? out_col : wd - 1;
        cs[0] = (oc == 0) ? 0 : oc - 1;
        cs[1] = oc;
        cs[2] = (oc + 1 < wd) ? oc + 1 : wd - 1;
        for (int c = 0; c < 3; c++) begin
          w[c]   = row_up[cs[c]];
          w[3+c] = row_lo[cs[c]];
          w[6+c] = row_lo[cs[c]];
        end
        blend_window(w);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    px_out_t exp_px;
    if (!rst_ni) begin
      k_top = '0; k_mid = 48'd16384; k_bot = '0;
      blend_w = 9'd256; alpha_on = 1'b0;
      width_q = 13'd1920; height_q = 13'd1080;
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      expected_px.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_px.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%t unexpected result tdata=%h tlast=%b", $realtime, m_tdata_i, m_tlast_i);
        end else begin
          exp_px = expected_px.pop_front();
          checked_o++;
          if (exp_px.px !== m_tdata_i || exp_px.eof !== m_tlast_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%t mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                       $realtime, exp_px.px, exp_px.eof, m_tdata_i, m_tlast_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_KTOP:  k_top = cfg_data_i[47:0];
          REG_KMID:  k_mid = cfg_data_i[47:0];
          REG_KBOT:  k_bot = cfg_data_i[47:0];
          REG_STR:   blend_w = cfg_data_i[8:0];
          REG_FALPH: alpha_on = cfg_data_i[0];
          REG_WIDTH, REG_HGHT: begin
            if (reg_e'(cfg_index_i) == REG_WIDTH) width_q = cfg_data_i[12:0];
            else height_q = cfg_data_i[12:0];
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
          end
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) take_item(s_tuser_i, s_tdata_i);
    end
    pending_o = expected_px.size();
  end

endmodule

// ----- verif/conv3x3_clamp_edge_blend_test.sv -----
`timescale 1ns / 1ps
module conv3x3_clamp_edge_blend_test;
  import ccb_pkg::*;
  import ccb_tb_pkg::*;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_PIXEL;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  int fail_count, pending, checked;
  int n_sent = 0, planes = 0, stall_cnt = 0;
  bit calm = 1'b0, hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  conv3x3_clamp_edge_blend dut (.*);

  conv3x3_clamp_edge_blend_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tlast_i(m_axis_tlast),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Result sink: random stalls, plus one long hold-off on request.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      m_axis_tready = 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      hold_req = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles, %0d results pending",
                 StallLimit, pending);
        $display("** conv3x3_clamp_edge_blend: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_e idx, logic [63:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold off new items until every result is back and the block has settled.
  task automatic drain_idle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Leaves tvalid high so back-to-back items need no gap.
  task automatic send_item(logic op, logic [63:0] data);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_sent++;
  endtask

  function automatic logic [63:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int flushes_needed(int w, int h);
    if (h == 1) return w;
    return w * h - (h - 1) * (w - 1) - (h - 2);
  endfunction

  task automatic set_size(int w, int h);
    write_reg(REG_WIDTH, 64'(w));
    write_reg(REG_HGHT, 64'(h));
  endtask

  task automatic random_regs();
    write_reg(REG_KTOP, {16'd0, 16'($urandom_range(0, 65535)), $urandom});
    write_reg(REG_KMID, {16'd0, 16'($urandom_range(0, 65535)), $urandom});
    write_reg(REG_KBOT, {16'd0, 16'($urandom_range(0, 65535)), $urandom});
    case ($urandom_range(0, 3))
      0:       write_reg(REG_STR, 64'd0);
      1:       write_reg(REG_STR, 64'd256);
      default: write_reg(REG_STR, 64'($urandom_range(0, 256)));
    endcase
    write_reg(REG_FALPH, 64'($urandom_range(0, 1)));
  endtask

  // One plane: optionally cut short (aborted by the next size write), with noise items.
  task automatic run_plane(int w, int h, bit cut);
    int total, stop;
    total = w * h;
    stop = cut ? $urandom_range(0, total - 1) : total;
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(0, 29) == 0) send_item(OP_FLUSH, {$urandom, $urandom});
      send_item(OP_PIXEL, rand_pixel());
    end
    if (!cut) begin
      if ($urandom_range(0, 3) == 0) send_item(OP_PIXEL, rand_pixel());
      repeat (flushes_needed(w, h)) send_item(OP_FLUSH, {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) send_item(OP_FLUSH, '0);
    end
    planes++;
    drain_idle();
  endtask

  initial begin
    int rand_base, w, h;
    bit held;
    held = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extreme weights, full blend, alpha filtered, 3x3 plane.
    write_reg(REG_KTOP, 64'h7FFF_8000_0001);
    write_reg(REG_KMID, 64'h0000_4000_0000);
    write_reg(REG_KBOT, 64'hFFFF_0000_7FFF);
    write_reg(REG_STR, 64'd256);
    write_reg(REG_FALPH, 64'd1);
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(OP_FLUSH, '0);
      send_item(OP_PIXEL, (i % 3 == 0) ? 64'd0 : ((i % 3 == 1) ? '1 : {$urandom, $urandom}));
    end
    send_item(OP_PIXEL, '1);
    repeat (flushes_needed(3, 3)) send_item(OP_FLUSH, '1);
    planes++;
    drain_idle();

    // Single-pixel plane, no blend, alpha passed through.
    write_reg(REG_STR, 64'd0);
    write_reg(REG_FALPH, 64'd0);
    set_size(1, 1);
    send_item(OP_PIXEL, '1);
    send_item(OP_FLUSH, '0);
    planes++;
    drain_idle();

    // Wide single row and tall single column.
    random_regs();
    set_size(60, 1);
    run_plane(60, 1, 1'b0);
    random_regs();
    set_size(1, 60);
    run_plane(1, 60, 1'b0);

    rand_base = n_sent;
    while (n_sent - rand_base < 930) begin
      if (n_sent - rand_base > 830) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) random_regs();
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      h = $urandom_range(1, 5);
      set_size(w, h);
      if (!held && n_sent - rand_base > 300) begin
        hold_req = 1'b1;
        held = 1'b1;
        run_plane(w, h, 1'b0);
      end else begin
        run_plane(w, h, $urandom_range(0, 9) == 0);
      end
    end

    $display("Ran %0d items over %0d planes (1x1 up to 60 wide or tall, some cut short,",
             n_sent, planes);
    $display("one long output hold-off), %0d results checked", checked);
    if (fail_count == 0) begin
      $display("** conv3x3_clamp_edge_blend: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** conv3x3_clamp_edge_blend: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ccb_pkg.sv
hw/rtl/ccb_ctrl.sv
hw/rtl/ccb_dpath.sv
hw/rtl/conv3x3_clamp_edge_blend.sv
verif/ccb_tb_pkg.sv
verif/conv3x3_clamp_edge_blend_checker.sv
verif/conv3x3_clamp_edge_blend_test.sv
